@@ sv/bcd_pkg.sv @@
package bcd_pkg;

  // configuration register indexes
  typedef enum logic {
    REG_BLOCK_FORMAT = 1'b0,
    REG_BYTE_SWAP    = 1'b1
  } reg_idx_e;

  localparam int unsigned TEXEL_W = 32;

  // Decoded block: the format flag, the color palette, the alpha ramp and the raw index bits.
  typedef struct packed {
    logic                        bc3;
    logic [3:0][TEXEL_W-1:0]     pal;
    logic [7:0][7:0]             alpha;
    logic [31:0]                 cidx;
    logic [47:0]                 aidx;
  } blk_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x < 768: multiply by ceil(2^12 / 3)
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1366;
    return p[19:12];
  endfunction

  // x / 5 for x <= 1275: multiply by ceil(2^13 / 5)
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  // x / 7 for x <= 1785: multiply by ceil(2^14 / 7)
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

endpackage

@@ sv/bcd_palette.sv @@
module bcd_palette (
  input  logic [63:0]       h0_i,
  input  logic [63:0]       h1_i,
  input  logic              bc3_i,
  output bcd_pkg::blk_t     blk_o
);

  logic [63:0]     cblk;
  logic [15:0]     c0, c1;
  logic [2:0][7:0] e0, e1;
  logic            four;
  logic [7:0]      a0, a1;
  logic [9:0]      s20, s02;
  logic [8:0]      s11;
  logic [10:0]     x7, x5;

  assign cblk = bc3_i ? h1_i : h0_i;
  assign c0   = cblk[15:0];
  assign c1   = cblk[31:16];
  assign four = bc3_i || (c0 > c1);
  assign a0   = h0_i[7:0];
  assign a1   = h0_i[15:8];

  // endpoint channels: index 0 red, 1 green, 2 blue
  assign e0[0] = bcd_pkg::widen5(c0[15:11]);
  assign e0[1] = bcd_pkg::widen6(c0[10:5]);
  assign e0[2] = bcd_pkg::widen5(c0[4:0]);
  assign e1[0] = bcd_pkg::widen5(c1[15:11]);
  assign e1[1] = bcd_pkg::widen6(c1[10:5]);
  assign e1[2] = bcd_pkg::widen5(c1[4:0]);

  always_comb begin
    blk_o.bc3  = bc3_i;
    blk_o.cidx = cblk[63:32];
    blk_o.aidx = h0_i[63:16];
    blk_o.pal[0] = {8'hff, e0[2], e0[1], e0[0]};
    blk_o.pal[1] = {8'hff, e1[2], e1[1], e1[0]};
    blk_o.pal[2] = 32'hff00_0000;
    blk_o.pal[3] = four ? 32'hff00_0000 : 32'h0;
    s20 = '0;
    s02 = '0;
    s11 = '0;
    for (int k = 0; k < 3; k++) begin
      s20 = {1'b0, e0[k], 1'b0} + 10'(e1[k]);
      s02 = 10'(e0[k]) + {1'b0, e1[k], 1'b0};
      s11 = 9'(e0[k]) + 9'(e1[k]);
      if (four) begin
        blk_o.pal[2][8*k +: 8] = bcd_pkg::div3(s20);
        blk_o.pal[3][8*k +: 8] = bcd_pkg::div3(s02);
      end else begin
        blk_o.pal[2][8*k +: 8] = s11[8:1];
      end
    end

    // alpha ramp: eight levels when a0 > a1, else six plus 0 and 255
    blk_o.alpha[0] = a0;
    blk_o.alpha[1] = a1;
    x7 = '0;
    x5 = '0;
    for (int k = 1; k < 7; k++) begin
      x7 = 11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1);
      blk_o.alpha[k+1] = bcd_pkg::div7(x7);
    end
    if (!(a0 > a1)) begin
      for (int k = 1; k < 5; k++) begin
        x5 = 11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1);
        blk_o.alpha[k+1] = bcd_pkg::div5(x5);
      end
      blk_o.alpha[6] = 8'h00;
      blk_o.alpha[7] = 8'hff;
    end
  end

endmodule

@@ sv/bcd_row_emit.sv @@
module bcd_row_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              blk_valid_i,
  input  bcd_pkg::blk_t     blk_i,
  output logic              blk_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        row_o,
  output logic [31:0]       texel0_o,
  output logic [31:0]       texel1_o,
  output logic [31:0]       texel2_o,
  output logic [31:0]       texel3_o,
  output logic              last_o
);

  bcd_pkg::blk_t    blk_q;
  logic             blk_valid_q, blk_valid_d;
  logic [1:0]       row_q, row_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_row_q;
  logic [3:0][31:0] tex_q, tex_d;
  logic             blk_load, c_load;
  logic [7:0]       cbits;
  logic [11:0]      abits;

  assign c_load      = blk_valid_q && (!out_valid_q || out_ready_i);
  assign blk_ready_o = !blk_valid_q || (c_load && row_q == 2'd3);
  assign blk_load    = blk_valid_i && blk_ready_o;

  always_comb begin
    blk_valid_d = blk_valid_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    if (blk_load) begin
      blk_valid_d = 1'b1;
      row_d       = 2'd0;
    end else if (c_load) begin
      blk_valid_d = (row_q != 2'd3);
      row_d       = row_q + 2'd1;
    end
    if (c_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // select this row's index bits and look up four texels
  assign cbits = blk_q.cidx[{row_q, 3'b000} +: 8];
  assign abits = blk_q.aidx[6'(row_q) * 6'd12 +: 12];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tex_d[c] = blk_q.pal[cbits[2*c +: 2]];
      if (blk_q.bc3) begin
        tex_d[c][31:24] = blk_q.alpha[abits[3*c +: 3]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      row_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      blk_valid_q <= blk_valid_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_load) begin
      blk_q <= blk_i;
    end
    if (c_load) begin
      tex_q     <= tex_d;
      out_row_q <= row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = out_row_q;
  assign last_o      = (out_row_q == 2'd3);
  assign texel0_o    = tex_q[0];
  assign texel1_o    = tex_q[1];
  assign texel2_o    = tex_q[2];
  assign texel3_o    = tex_q[3];

  // a row taken that is not the last is followed at once by the next row
  a_row_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && out_row_q != 2'd3
    |=> out_valid_q && out_row_q == $past(out_row_q) + 2'd1)
    else $error("next row of block not presented");

  // a held block never leaves the output register empty
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_q && !out_valid_q |=> out_valid_q)
    else $error("bubble while block is pending");

  // a new block replaces a held one only as its fourth row is loaded into the output register
  a_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_load && blk_valid_q |-> row_q == 2'd3 && c_load)
    else $error("block overwritten before all rows sent");

endmodule

@@ sv/bc1_bc3_block_decoder.sv @@
// BC1 / BC3 (DXT1 / DXT5) block decoder. Each input word is one compressed
// 4x4 block: first_half_i holds bytes 0..7 (the BC1 color block, or the BC3
// alpha block), second_half_i holds bytes 8..15 (the BC3 color block, ignored
// for BC1). Each block comes out as four output words, rows 0..3 in order,
// each carrying four RGBA texels (red 7..0, green 15..8, blue 23..16,
// alpha 31..24); last_o marks row 3. The output port moves one row per cycle
// while out_ready_i is high and a block is held; the row emitter is the pacing
// unit. The first row reaches the output through the input register, which
// loads as its block is accepted, then the decoded-block register and then the
// output register. The input register frees as soon as the decoded-block
// register takes its contents, so the next block is accepted while rows of the
// current one are still going out. Configuration: register 0 (block_format)
// selects BC1 (0) or BC3 (1); register 1 (byte_swap) exchanges the two bytes
// of every 16-bit word of the block.
// Write configuration only while the decoder is idle.
module bc1_bc3_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] first_half_i,
  input  logic [63:0] second_half_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  row_o,
  output logic [31:0] texel0_o,
  output logic [31:0] texel1_o,
  output logic [31:0] texel2_o,
  output logic [31:0] texel3_o,
  output logic        last_o
);

  localparam logic [63:0] LoByteMask = 64'h00ff_00ff_00ff_00ff;

  logic          fmt_q, swap_q;
  logic          in_valid_q, in_valid_d;
  logic [63:0]   h0_q, h1_q;
  logic [63:0]   h0_sw, h1_sw;
  logic          blk_ready;
  logic          in_load;
  bcd_pkg::blk_t blk;

  // Configuration registers: write at once, drop writes to unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= 1'b0;
      swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (bcd_pkg::reg_idx_e'(cfg_index_i))
        bcd_pkg::REG_BLOCK_FORMAT: fmt_q  <= cfg_data_i;
        bcd_pkg::REG_BYTE_SWAP:    swap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Exchange bytes within each 16-bit word for big-endian blocks.
  assign h0_sw = swap_q ? (((first_half_i >> 8) & LoByteMask) |
                           ((first_half_i & LoByteMask) << 8)) : first_half_i;
  assign h1_sw = swap_q ? (((second_half_i >> 8) & LoByteMask) |
                           ((second_half_i & LoByteMask) << 8)) : second_half_i;

  // Input register: free when empty or when its block moves on this cycle.
  assign in_ready_o = !in_valid_q || blk_ready;
  assign in_load    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (blk_ready) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      h0_q <= h0_sw;
      h1_q <= h1_sw;
    end
  end

  // Build the color palette and the alpha ramp in one pass.
  bcd_palette u_palette (
    .h0_i  (h0_q),
    .h1_i  (h1_q),
    .bc3_i (fmt_q),
    .blk_o (blk)
  );

  // Hold the decoded block and advance one row per output word.
  bcd_row_emit u_row_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (in_valid_q),
    .blk_i       (blk),
    .blk_ready_o (blk_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_o       (row_o),
    .texel0_o    (texel0_o),
    .texel1_o    (texel1_o),
    .texel2_o    (texel2_o),
    .texel3_o    (texel3_o),
    .last_o      (last_o)
  );

endmodule
